// ----- rtl/memcomparable_key_encoder_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the key encoder RTL.
// Each macro expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef MEMCOMPARABLE_KEY_ENCODER_ASSERT_SVH
`define MEMCOMPARABLE_KEY_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define MKE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MKE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mke_pkg.sv -----
// ---------------------------------------------------------------------------
// mke_pkg
// Types and constants for the order-preserving key encoder.
// ---------------------------------------------------------------------------
package mke_pkg;

	localparam int unsigned JOB_BYTES   = 9;
	localparam int unsigned CNT_W       = $clog2(JOB_BYTES + 1);
	// queue depth must be a power of two (pointers wrap naturally)
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [3:0] KIND_BOOL   = 4'd0;
	localparam logic [3:0] KIND_INT8   = 4'd1;
	localparam logic [3:0] KIND_INT16  = 4'd2;
	localparam logic [3:0] KIND_INT32  = 4'd3;
	localparam logic [3:0] KIND_INT64  = 4'd4;
	localparam logic [3:0] KIND_UINT8  = 4'd5;
	localparam logic [3:0] KIND_UINT16 = 4'd6;
	localparam logic [3:0] KIND_UINT32 = 4'd7;
	localparam logic [3:0] KIND_UINT64 = 4'd8;
	localparam logic [3:0] KIND_FLOAT  = 4'd9;
	localparam logic [3:0] KIND_DOUBLE = 4'd10;
	localparam logic [3:0] KIND_STRING = 4'd11;

	localparam logic [31:0] SIGN32      = 32'h8000_0000;
	localparam logic [63:0] SIGN64      = 64'h8000_0000_0000_0000;
	localparam logic [7:0]  MARK_MORE   = 8'hFF;
	localparam logic [3:0]  GROUP_BYTES = 4'd8;

	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] value_bits;
		logic [3:0]  grp_len;
		logic        group_last;
		logic        descending;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} result_t;

	// bytes[0] goes out first; cnt is 1..JOB_BYTES
	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          cnt;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} q_wr_t;

	typedef struct packed {
		logic avail;
		job_t job;
	} q_rd_t;

endpackage

// ----- rtl/memcomparable_key_encoder.sv -----
// ---------------------------------------------------------------------------
// memcomparable_key_encoder
// Order-preserving key byte encoder, top level.
// ---------------------------------------------------------------------------
// Each accepted item becomes 1, 2, 4, 8 or 9 key bytes (bool and 8-bit types
// one, 16-bit two, 32-bit and float four, 64-bit and double eight, a string
// group nine); unused kinds give none. The output carries one byte per cycle
// while result_stall is low, so an item's bytes leave one after another and
// the output side sets the sustained rate. Input items are taken one per
// cycle while the four-entry job queue has room; each item travels through
// the front register, the job queue and the output register.
// ---------------------------------------------------------------------------
module memcomparable_key_encoder (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  mke_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output mke_pkg::result_t result
);

	mke_pkg::q_wr_t wr;
	mke_pkg::q_rd_t rd;
	logic           q_full;
	logic           pop;

	mke_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.wr         (wr)
	);

	mke_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.full   (q_full),
		.pop    (pop),
		.rd     (rd)
	);

	mke_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd           (rd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- rtl/mke_front.sv -----
// ---------------------------------------------------------------------------
// mke_front
// Accepts key items, encodes them into a byte job and hands the job to the
// queue. Items that produce no bytes are dropped here.
// ---------------------------------------------------------------------------
module mke_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  mke_pkg::item_t  item,
	input  logic            q_full,
	output mke_pkg::q_wr_t  wr
);

	logic [63:0]                       v;
	logic [63:0]                       word;
	logic [3:0]                        len;
	logic [7:0]                        marker;
	logic [31:0]                       flt;
	logic [mke_pkg::CNT_W-1:0]         cnt_c;
	logic [mke_pkg::JOB_BYTES-1:0][7:0] bytes_c;

	logic         valid_s1;
	mke_pkg::job_t job_s1;

	assign v   = item.value_bits;
	assign flt = v[31:0];
	assign len = (item.grp_len > mke_pkg::GROUP_BYTES) ? mke_pkg::GROUP_BYTES
	                                                   : item.grp_len;

	// left-aligned big-endian word plus byte count
	always_comb begin
		word   = '0;
		marker = '0;
		cnt_c  = '0;
		case (item.kind)
			mke_pkg::KIND_BOOL: begin
				word[63:56] = (v != 64'd0) ? 8'h01 : 8'h00;
				cnt_c       = mke_pkg::CNT_W'(1);
			end
			mke_pkg::KIND_INT8: begin
				word[63:56] = v[7:0] ^ mke_pkg::SIGN32[31:24];
				cnt_c       = mke_pkg::CNT_W'(1);
			end
			mke_pkg::KIND_INT16: begin
				word[63:48] = v[15:0] ^ mke_pkg::SIGN32[31:16];
				cnt_c       = mke_pkg::CNT_W'(2);
			end
			mke_pkg::KIND_INT32: begin
				word[63:32] = v[31:0] ^ mke_pkg::SIGN32;
				cnt_c       = mke_pkg::CNT_W'(4);
			end
			mke_pkg::KIND_INT64: begin
				word  = v ^ mke_pkg::SIGN64;
				cnt_c = mke_pkg::CNT_W'(8);
			end
			mke_pkg::KIND_UINT8: begin
				word[63:56] = v[7:0];
				cnt_c       = mke_pkg::CNT_W'(1);
			end
			mke_pkg::KIND_UINT16: begin
				word[63:48] = v[15:0];
				cnt_c       = mke_pkg::CNT_W'(2);
			end
			mke_pkg::KIND_UINT32: begin
				word[63:32] = v[31:0];
				cnt_c       = mke_pkg::CNT_W'(4);
			end
			mke_pkg::KIND_UINT64: begin
				word  = v;
				cnt_c = mke_pkg::CNT_W'(8);
			end
			mke_pkg::KIND_FLOAT: begin
				word[63:32] = flt[31] ? ~flt : (flt ^ mke_pkg::SIGN32);
				cnt_c       = mke_pkg::CNT_W'(4);
			end
			mke_pkg::KIND_DOUBLE: begin
				word  = v[63] ? ~v : (v ^ mke_pkg::SIGN64);
				cnt_c = mke_pkg::CNT_W'(8);
			end
			mke_pkg::KIND_STRING: begin
				// bytes past the group length go out as zero padding
				for (int k = 0; k < 8; k++) begin
					if (4'(k) < len)
						word[63-8*k -: 8] = v[63-8*k -: 8];
				end
				marker = item.group_last ? {4'd0, len} : mke_pkg::MARK_MORE;
				cnt_c  = mke_pkg::CNT_W'(mke_pkg::JOB_BYTES);
			end
			default: begin
				cnt_c = '0;
			end
		endcase
	end

	always_comb begin
		for (int k = 0; k < 8; k++)
			bytes_c[k] = word[63-8*k -: 8];
		bytes_c[8] = marker;
		if (item.descending)
			bytes_c = ~bytes_c;
	end

	// register empties on push; full queue holds the stage
	assign item_stall = valid_s1 && q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid && (cnt_c != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			job_s1.bytes <= bytes_c;
			job_s1.cnt   <= cnt_c;
		end
	end

	assign wr.push = valid_s1 && !q_full;
	assign wr.job  = job_s1;

endmodule

// ----- rtl/mke_queue.sv -----
// ---------------------------------------------------------------------------
// mke_queue
// Small job queue between the encoder front and the byte serializer.
// ---------------------------------------------------------------------------
`include "memcomparable_key_encoder_assert.svh"

module mke_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  mke_pkg::q_wr_t wr,
	output logic           full,
	input  logic           pop,
	output mke_pkg::q_rd_t rd
);

	mke_pkg::job_t                 entries_q [mke_pkg::QUEUE_DEPTH];
	logic [mke_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [mke_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [mke_pkg::QPTR_W:0]      count_q;

	assign full     = (count_q == (mke_pkg::QPTR_W+1)'(mke_pkg::QUEUE_DEPTH));
	assign rd.avail = (count_q != '0);
	assign rd.job   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr.push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr.push)
			entries_q[wr_ptr_q] <= wr.job;
	end

	`MKE_ASSERT_NOW(a_no_push_full, wr.push, !full, "push into full queue")
	`MKE_ASSERT_NOW(a_no_pop_empty, pop, rd.avail, "pop from empty queue")
	`MKE_ASSERT_NOW(a_count_range, 1'b1, count_q <= (mke_pkg::QPTR_W+1)'(mke_pkg::QUEUE_DEPTH), "queue count overflow")
	`MKE_ASSERT_NEXT(a_push_fills, wr.push && !pop, rd.avail, "queue empty after push")

endmodule

// ----- rtl/mke_back.sv -----
// ---------------------------------------------------------------------------
// mke_back
// Serializes the job at the head of the queue, one byte per transfer, into
// an output register.
// ---------------------------------------------------------------------------
`include "memcomparable_key_encoder_assert.svh"

module mke_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mke_pkg::q_rd_t   rd,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output mke_pkg::result_t result
);

	logic [mke_pkg::CNT_W-1:0] idx_q;
	logic                      result_valid_q;
	mke_pkg::result_t          result_q;
	logic                      advance;
	logic                      issue;
	logic                      last;

	assign advance = !result_valid_q || !result_stall;
	assign issue   = advance && rd.avail;
	assign last    = (idx_q == rd.job.cnt - 1'b1);
	assign pop     = issue && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			idx_q          <= '0;
		end else begin
			if (advance)
				result_valid_q <= rd.avail;
			if (issue)
				idx_q <= last ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			result_q.out_byte  <= rd.job.bytes[idx_q];
			result_q.last_byte <= last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`MKE_ASSERT_NOW(a_idx_in_job, rd.avail, idx_q < rd.job.cnt, "byte index past job end")
	`MKE_ASSERT_NOW(a_idx_idle, !rd.avail, idx_q == '0, "byte index not cleared")
	`MKE_ASSERT_NEXT(a_last_flag, pop, result_valid_q && result_q.last_byte, "last byte not flagged")

endmodule
